[src/quadruped_gait_sequencer_assert.svh]
// assertion macros for the quadruped gait sequencer
`ifndef QUADRUPED_GAIT_SEQUENCER_ASSERT_SVH
`define QUADRUPED_GAIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define QGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qgs assertion failed");
`define QGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qgs assertion failed");
`else
`define QGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define QGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/qgs_pkg.sv]
// types, codes and angle constants shared by the gait sequencer modules
package qgs_pkg;

    typedef enum logic [1:0] {
        KIND_SERVO  = 2'd0,
        KIND_HOME   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SPEED = 2'd1,
        ST_BAD_DIR   = 2'd2
    } t_status;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_HALT  = 3'd4;

    localparam logic [1:0] SPD_SLOW = 2'd1;
    localparam logic [1:0] SPD_FAST = 2'd3;

    localparam logic [1:0] CFG_SLOW   = 2'd0;
    localparam logic [1:0] CFG_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_FAST   = 2'd2;

    localparam logic [7:0] SLOW_RESET   = 8'd150;
    localparam logic [7:0] MEDIUM_RESET = 8'd100;
    localparam logic [7:0] FAST_RESET   = 8'd50;

    localparam logic [2:0] SRV_RF_SH  = 3'd0;
    localparam logic [2:0] SRV_RF_ARM = 3'd1;
    localparam logic [2:0] SRV_LF_SH  = 3'd2;
    localparam logic [2:0] SRV_LF_ARM = 3'd3;
    localparam logic [2:0] SRV_RB_SH  = 3'd4;
    localparam logic [2:0] SRV_RB_ARM = 3'd5;
    localparam logic [2:0] SRV_LB_SH  = 3'd6;
    localparam logic [2:0] SRV_LB_ARM = 3'd7;

    localparam logic [7:0] ANG_SH_FWD  = 8'd60;
    localparam logic [7:0] ANG_SH_BACK = 8'd120;
    localparam logic [7:0] ANG_NEUTRAL = 8'd90;
    localparam logic [7:0] ANG_LIFT    = 8'd45;
    localparam logic [7:0] ANG_SWING   = 8'd30;
    localparam logic [7:0] ANG_MAX     = 8'd180;
    localparam logic [7:0] ANG_OTHER_FWD  = ANG_SH_BACK + ANG_SWING;
    localparam logic [7:0] ANG_OTHER_BACK = ANG_SH_FWD + ANG_SWING;

    localparam logic [5:0] STEP_MAX   = 6'd45;
    localparam logic [3:0] WALK_PHASES = 4'd6;
    localparam logic [3:0] SIDE_PHASES = 4'd9;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  idx;
        logic [7:0]  angle;
        t_status     status;
    } t_res;

    // up to four result beats made by one item
    typedef struct packed {
        logic [2:0]     cnt;
        t_res [3:0]     ent;
    } t_grp;

    function automatic t_res qgs_servo(input logic [2:0] idx, input logic [7:0] ang);
        t_res r;
        r.kind   = KIND_SERVO;
        r.idx    = idx;
        r.angle  = ang;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_res qgs_note(input t_kind kind, input t_status st);
        t_res r;
        r.kind   = kind;
        r.idx    = 3'd0;
        r.angle  = 8'd0;
        r.status = st;
        return r;
    endfunction

endpackage

[src/qgs_phase.sv]
// servo write table for one gait phase (diagonal-pair walk and sidestep)
module qgs_phase (
    input  logic [2:0]   i_dir,
    input  logic [3:0]   i_phase,
    input  logic [5:0]   i_step,
    output qgs_pkg::t_grp o_grp
);

    logic       walk;
    logic       fwd;
    logic       left;
    logic [7:0] s_ang;
    logic [7:0] o_ang;
    logic [1:0] grp_no;
    logic [1:0] sub_no;
    logic [2:0] sh1;
    logic [2:0] sh2;
    logic [7:0] target;

    assign walk = (i_dir == qgs_pkg::DIR_FWD) || (i_dir == qgs_pkg::DIR_BACK);
    assign fwd  = (i_dir == qgs_pkg::DIR_FWD);
    assign left = (i_dir == qgs_pkg::DIR_LEFT);

    always_comb begin
        o_grp  = '0;
        s_ang  = fwd ? qgs_pkg::ANG_SH_FWD : qgs_pkg::ANG_SH_BACK;
        o_ang  = fwd ? qgs_pkg::ANG_OTHER_FWD : qgs_pkg::ANG_OTHER_BACK;
        case (i_phase)
            4'd0, 4'd1, 4'd2: begin grp_no = 2'd0; end
            4'd3, 4'd4, 4'd5: begin grp_no = 2'd1; end
            default: begin grp_no = 2'd2; end
        endcase
        case (i_phase)
            4'd0, 4'd3, 4'd6: begin sub_no = 2'd0; end
            4'd1, 4'd4, 4'd7: begin sub_no = 2'd1; end
            default: begin sub_no = 2'd2; end
        endcase
        // side a leads and closes the sidestep, side b moves in the middle group
        if (grp_no == 2'd1) begin
            sh1 = left ? qgs_pkg::SRV_LF_SH : qgs_pkg::SRV_RF_SH;
            sh2 = left ? qgs_pkg::SRV_LB_SH : qgs_pkg::SRV_RB_SH;
        end else begin
            sh1 = left ? qgs_pkg::SRV_RF_SH : qgs_pkg::SRV_LF_SH;
            sh2 = left ? qgs_pkg::SRV_RB_SH : qgs_pkg::SRV_LB_SH;
        end
        if (grp_no == 2'd2) begin
            target = qgs_pkg::ANG_NEUTRAL;
        end else if (left) begin
            target = qgs_pkg::ANG_NEUTRAL + {2'b00, i_step};
        end else begin
            target = qgs_pkg::ANG_NEUTRAL - {2'b00, i_step};
        end

        if (walk) begin
            case (i_phase)
                4'd0: begin
                    o_grp.cnt    = 3'd2;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RF_ARM, qgs_pkg::ANG_LIFT);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LB_ARM, qgs_pkg::ANG_LIFT);
                end
                4'd1: begin
                    o_grp.cnt    = 3'd4;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RF_SH, s_ang);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LF_SH, o_ang);
                    o_grp.ent[2] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RB_SH, o_ang);
                    o_grp.ent[3] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LB_SH, s_ang);
                end
                4'd2: begin
                    o_grp.cnt    = 3'd2;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RF_ARM, qgs_pkg::ANG_NEUTRAL);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LB_ARM, qgs_pkg::ANG_NEUTRAL);
                end
                4'd3: begin
                    o_grp.cnt    = 3'd2;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LF_ARM, qgs_pkg::ANG_LIFT);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RB_ARM, qgs_pkg::ANG_LIFT);
                end
                4'd4: begin
                    o_grp.cnt    = 3'd4;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LF_SH, s_ang);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RF_SH, o_ang);
                    o_grp.ent[2] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LB_SH, o_ang);
                    o_grp.ent[3] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RB_SH, s_ang);
                end
                default: begin
                    o_grp.cnt    = 3'd2;
                    o_grp.ent[0] = qgs_pkg::qgs_servo(qgs_pkg::SRV_LF_ARM, qgs_pkg::ANG_NEUTRAL);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(qgs_pkg::SRV_RB_ARM, qgs_pkg::ANG_NEUTRAL);
                end
            endcase
        end else begin
            o_grp.cnt = 3'd2;
            case (sub_no)
                2'd0: begin
                    o_grp.ent[0] = qgs_pkg::qgs_servo(sh1 | 3'd1, qgs_pkg::ANG_LIFT);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(sh2 | 3'd1, qgs_pkg::ANG_LIFT);
                end
                2'd1: begin
                    o_grp.ent[0] = qgs_pkg::qgs_servo(sh1, target);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(sh2, target);
                end
                default: begin
                    o_grp.ent[0] = qgs_pkg::qgs_servo(sh1 | 3'd1, qgs_pkg::ANG_NEUTRAL);
                    o_grp.ent[1] = qgs_pkg::qgs_servo(sh2 | 3'd1, qgs_pkg::ANG_NEUTRAL);
                end
            endcase
        end
    end

endmodule

[src/qgs_core.sv]
// command decode, gait state and phase timing for one item per pass
module qgs_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_opcode,
    input  logic [2:0]    i_direction,
    input  logic [7:0]    i_heading,
    input  logic [7:0]    i_pace,
    input  logic [7:0]    i_slow,
    input  logic [7:0]    i_medium,
    input  logic [7:0]    i_fast,
    output qgs_pkg::t_grp o_grp
);

    logic        r_active, n_active;
    logic [2:0]  r_sdir, n_sdir;
    logic [7:0]  r_sang, n_sang;
    logic [1:0]  r_sspd, n_sspd;
    logic        r_in_cyc, n_in_cyc;
    logic [2:0]  r_cdir, n_cdir;
    logic [5:0]  r_cstep, n_cstep;
    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_wait, n_wait;

    logic        pace_ok;
    logic        go;
    logic        closing;
    logic        running;
    logic        start;
    logic [3:0]  nph;
    logic [6:0]  half_ang;
    logic [5:0]  start_step;
    logic [7:0]  delay;
    logic [2:0]  eff_dir;
    logic [3:0]  eff_phase;
    logic [5:0]  eff_step;
    qgs_pkg::t_grp phase_grp;

    qgs_phase u_phase (
        .i_dir   (eff_dir),
        .i_phase (eff_phase),
        .i_step  (eff_step),
        .o_grp   (phase_grp)
    );

    assign pace_ok    = (i_pace >= 8'd1) && (i_pace <= 8'd3);
    assign go         = (r_wait == 8'd0) || (r_wait == 8'd1);
    assign nph        = ((r_cdir == qgs_pkg::DIR_FWD) || (r_cdir == qgs_pkg::DIR_BACK)) ?
                        qgs_pkg::WALK_PHASES : qgs_pkg::SIDE_PHASES;
    assign closing    = r_in_cyc && (r_phase >= nph);
    assign running    = r_in_cyc && !closing;
    assign start      = !running && r_active && (r_sdir < qgs_pkg::DIR_HALT);
    // angle * 45 / 90 is half the angle, held to the largest sidestep
    assign half_ang   = r_sang[7:1];
    assign start_step = (half_ang > {1'b0, qgs_pkg::STEP_MAX}) ? qgs_pkg::STEP_MAX
                                                              : half_ang[5:0];
    assign eff_dir    = start ? r_sdir : r_cdir;
    assign eff_phase  = start ? 4'd0 : r_phase;
    assign eff_step   = start ? start_step : r_cstep;

    always_comb begin
        case (r_sspd)
            qgs_pkg::SPD_SLOW: begin delay = i_slow; end
            qgs_pkg::SPD_FAST: begin delay = i_fast; end
            default: begin delay = i_medium; end
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_sdir   = r_sdir;
        n_sang   = r_sang;
        n_sspd   = r_sspd;
        n_in_cyc = r_in_cyc;
        n_cdir   = r_cdir;
        n_cstep  = r_cstep;
        n_phase  = r_phase;
        n_wait   = r_wait;
        o_grp    = '0;
        if (i_opcode == qgs_pkg::OP_CMD) begin
            if (!pace_ok) begin
                o_grp.cnt    = 3'd1;
                o_grp.ent[0] = qgs_pkg::qgs_note(qgs_pkg::KIND_STATUS, qgs_pkg::ST_BAD_SPEED);
            end else begin
                n_sdir = i_direction;
                n_sang = (i_heading > qgs_pkg::ANG_MAX) ? qgs_pkg::ANG_MAX : i_heading;
                n_sspd = i_pace[1:0];
                if (i_direction < qgs_pkg::DIR_HALT) begin
                    n_active     = 1'b1;
                    o_grp.cnt    = 3'd1;
                    o_grp.ent[0] = qgs_pkg::qgs_note(qgs_pkg::KIND_STATUS, qgs_pkg::ST_OK);
                end else if (i_direction == qgs_pkg::DIR_HALT) begin
                    n_active     = 1'b0;
                    o_grp.cnt    = 3'd2;
                    o_grp.ent[0] = qgs_pkg::qgs_note(qgs_pkg::KIND_HOME, qgs_pkg::ST_OK);
                    o_grp.ent[1] = qgs_pkg::qgs_note(qgs_pkg::KIND_STATUS, qgs_pkg::ST_OK);
                end else begin
                    o_grp.cnt    = 3'd1;
                    o_grp.ent[0] = qgs_pkg::qgs_note(qgs_pkg::KIND_STATUS, qgs_pkg::ST_BAD_DIR);
                end
            end
        end else begin
            if (r_wait != 8'd0) begin
                n_wait = r_wait - 8'd1;
            end
            if (go) begin
                if (!running) begin
                    n_in_cyc = 1'b0;
                    if (r_active && (r_sdir == qgs_pkg::DIR_HALT)) begin
                        n_active     = 1'b0;
                        o_grp.cnt    = 3'd1;
                        o_grp.ent[0] = qgs_pkg::qgs_note(qgs_pkg::KIND_HOME, qgs_pkg::ST_OK);
                    end else if (r_active && (r_sdir > qgs_pkg::DIR_HALT)) begin
                        n_active = 1'b0;
                    end
                end
                if (start) begin
                    n_cdir   = r_sdir;
                    n_cstep  = start_step;
                    n_in_cyc = 1'b1;
                end
                if (running || start) begin
                    o_grp   = phase_grp;
                    n_phase = eff_phase + 4'd1;
                    n_wait  = delay;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sdir   <= '0;
            r_sang   <= '0;
            r_sspd   <= '0;
            r_in_cyc <= 1'b0;
            r_cdir   <= '0;
            r_cstep  <= '0;
            r_phase  <= '0;
            r_wait   <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_sdir   <= n_sdir;
            r_sang   <= n_sang;
            r_sspd   <= n_sspd;
            r_in_cyc <= n_in_cyc;
            r_cdir   <= n_cdir;
            r_cstep  <= n_cstep;
            r_phase  <= n_phase;
            r_wait   <= n_wait;
        end
    end

endmodule

[src/qgs_obuf.sv]
// result register holding one item's beats and handing them out one a cycle unless stalled
module qgs_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  qgs_pkg::t_grp i_grp,
    input  logic          i_stall,
    output logic          o_valid,
    output logic          o_last,
    output qgs_pkg::t_res o_res,
    output logic          o_free
);

    logic [2:0]          r_cnt;
    logic [1:0]          r_ptr;
    qgs_pkg::t_res [3:0] r_ent;
    logic                take;

    assign o_valid = (r_cnt != 3'd0);
    assign o_last  = ({1'b0, r_ptr} == (r_cnt - 3'd1));
    assign o_res   = r_ent[r_ptr];
    assign take    = o_valid && !i_stall;
    // free once empty or as the final beat leaves
    assign o_free  = !o_valid || (take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
            r_ptr <= '0;
        end else if (take) begin
            if (o_last) begin
                r_cnt <= '0;
            end else begin
                r_ptr <= r_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_grp.ent;
        end
    end

endmodule

[src/quadruped_gait_sequencer.sv]
// quadruped gait sequencer top level: input register, delay registers, core and result buffer
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_opcode i_direction i_heading i_pace
//  result    out        o_valid / i_stall    o_kind o_servo_index o_servo_angle o_status o_last
//  config    in         i_cfg_we             i_cfg_addr i_cfg_wdata
//
// an item waits in the input register until the result register frees, then a single
// pass through the core fills the result register with 0 to 4 beats, which leave one
// per cycle unless stalled; the input register frees as the last beat of the previous
// item goes, and until then a new item can wait in it while those beats leave
// reset is synchronous and clears the gait state and loads the default delays
// a stall on the result side holds the result register and backs up into o_stall
module quadruped_gait_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [2:0] i_direction,
    input  logic [7:0] i_heading,
    input  logic [7:0] i_pace,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [2:0] o_servo_index,
    output logic [7:0] o_servo_angle,
    output logic [1:0] o_status,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);

`include "quadruped_gait_sequencer_assert.svh"

    logic          r_in_valid;
    logic          r_opcode;
    logic [2:0]    r_direction;
    logic [7:0]    r_heading;
    logic [7:0]    r_pace;
    logic [7:0]    r_slow;
    logic [7:0]    r_medium;
    logic [7:0]    r_fast;
    logic          fire;
    logic          free;
    logic          accept;
    qgs_pkg::t_grp grp;
    qgs_pkg::t_res res;

    assign fire    = r_in_valid && free;
    assign o_stall = r_in_valid && !free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode    <= i_opcode;
            r_direction <= i_direction;
            r_heading   <= i_heading;
            r_pace      <= i_pace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow   <= qgs_pkg::SLOW_RESET;
            r_medium <= qgs_pkg::MEDIUM_RESET;
            r_fast   <= qgs_pkg::FAST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                qgs_pkg::CFG_SLOW: begin r_slow <= i_cfg_wdata; end
                qgs_pkg::CFG_MEDIUM: begin r_medium <= i_cfg_wdata; end
                qgs_pkg::CFG_FAST: begin r_fast <= i_cfg_wdata; end
                default: begin end
            endcase
        end
    end

    qgs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_opcode    (r_opcode),
        .i_direction (r_direction),
        .i_heading   (r_heading),
        .i_pace      (r_pace),
        .i_slow      (r_slow),
        .i_medium    (r_medium),
        .i_fast      (r_fast),
        .o_grp       (grp)
    );

    qgs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_grp   (grp),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_last  (o_last),
        .o_res   (res),
        .o_free  (free)
    );

    assign o_kind        = res.kind;
    assign o_servo_index = res.idx;
    assign o_servo_angle = res.angle;
    assign o_status      = res.status;

    // a beat that is not the last is followed by the rest of its item
    `QGS_ASSERT_NEXT(a_group_continues, i_clk, i_rst_n, o_valid && !o_last && !i_stall, o_valid)
    // the input side only waits while results are held
    `QGS_ASSERT_NOW(a_stall_needs_results, i_clk, i_rst_n, o_stall, o_valid && r_in_valid)
    // servo writes never carry a status code
    `QGS_ASSERT_NOW(a_servo_status_ok, i_clk, i_rst_n, o_valid && (o_kind == qgs_pkg::KIND_SERVO), o_status == qgs_pkg::ST_OK)

endmodule
